// ----- rtl/stbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and controller/datapath interface types for the sorted
// table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int DATA_W          = 32;
	localparam int IDX_W           = 8;
	localparam int CNT_W           = 9;
	localparam int TABLE_DEPTH_DEF = 256;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

	// input beat mode codes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic wr_en;     // table write beat
		logic start;     // search beat, load range and key
		logic rd_en;     // read probed entry
		logic step;      // compare and narrow range
		logic load_out;  // move result to output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic zero;  // effective entry count is zero
		logic hit;   // probed entry equals key
		logic last;  // range holds one entry
	} sts_t;

endpackage

// ----- rtl/stbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for the search: accepts beats, issues probe reads and compare
// steps, and owns the output valid.
// ----------------------------------------------------------------------------
module stbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            mode,
	output logic            out_valid,
	input  logic            out_stall,
	input  stbs_pkg::sts_t  sts,
	output stbs_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PROBE  = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.wr_en    = accept && (mode == stbs_pkg::MODE_WRITE);
		cmd.start    = accept && (mode == stbs_pkg::MODE_SEARCH);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (mode == stbs_pkg::MODE_SEARCH)) begin
					state_d = sts.zero ? ST_FINISH : ST_PROBE;
				end
			end
			ST_PROBE: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = (sts.hit || sts.last) ? ST_FINISH : ST_PROBE;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ($past(state_q) == ST_PROBE))
		else $error("compare without a preceding probe read");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken beat");

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && !sts.zero) |=> (state_q == ST_PROBE))
		else $error("search did not start probing");

endmodule

// ----- rtl/stbs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_dp
// Table memory, entry count register, search range registers and compare.
// ----------------------------------------------------------------------------
module stbs_dp #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic        [stbs_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic        [stbs_pkg::IDX_W-1:0]   entry_index,
	input  logic signed [stbs_pkg::DATA_W-1:0]  data_value,
	output logic                                found,
	input  stbs_pkg::cmd_t                      cmd,
	output stbs_pkg::sts_t                      sts
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic signed [stbs_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

	logic        [stbs_pkg::CNT_W-1:0]  cnt_q;
	logic        [CW-1:0]               cnt_sat;
	logic        [CW-1:0]               lo_q, hi_q;
	logic        [AW-1:0]               mid_q;
	logic signed [stbs_pkg::DATA_W-1:0] key_q;
	logic signed [stbs_pkg::DATA_W-1:0] rd_q;
	logic                               res_q;
	logic                               found_q;

	logic          wr_ok;
	logic          greater;
	logic [CW-1:0] mid_ext;
	logic [CW-1:0] lo_nx, hi_nx;
	logic [CW-1:0] mid_nx;

	always_comb begin
		if (32'(cnt_q) > TABLE_DEPTH) begin
			cnt_sat = CW'(TABLE_DEPTH);
		end else begin
			cnt_sat = CW'(cnt_q);
		end
	end

	assign wr_ok   = (32'(entry_index) < TABLE_DEPTH);
	assign greater = (key_q > rd_q);
	assign mid_ext = CW'(mid_q);
	assign lo_nx   = greater ? mid_ext : lo_q;
	assign hi_nx   = greater ? hi_q : mid_ext;
	assign mid_nx  = lo_nx + ((hi_nx - lo_nx) >> 1);

	assign sts.zero = (cnt_sat == '0);
	assign sts.hit  = (rd_q == key_q);
	assign sts.last = ((lo_q + CW'(1)) == hi_q);
	assign found    = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= stbs_pkg::CNT_RESET;
		end else if (cfg_wr_en) begin
			cnt_q <= cfg_wr_data;
		end
	end

	// table
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[AW'(entry_index)] <= data_value;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[mid_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q  <= '0;
			hi_q  <= cnt_sat;
			mid_q <= AW'(cnt_sat >> 1);
			key_q <= data_value;
			res_q <= 1'b0;
		end else if (cmd.step) begin
			lo_q  <= lo_nx;
			hi_q  <= hi_nx;
			mid_q <= AW'(mid_nx);
			res_q <= sts.hit;
		end
		if (cmd.load_out) begin
			found_q <= res_q;
		end
	end

	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (lo_q < hi_q))
		else $error("probe issued on an empty range");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> ((mid_ext >= lo_q) && (mid_ext < hi_q)))
		else $error("probe address outside search range");

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a table of signed 32-bit entries held in on-chip memory.
// ----------------------------------------------------------------------------
// A write beat (mode 0) stores data_value at entry_index and gives no
// result; indexes at or above TABLE_DEPTH are dropped. A search beat
// (mode 1) looks for data_value over entries 0 to entries_in_use-1 (count
// capped at TABLE_DEPTH) and returns one found beat. The table must be kept
// sorted ascending and every searched entry written first. A search makes
// at most ceil(log2(N))+1 probes over N entries; each probe reads the entry
// at the range midpoint, then compares it, on the single table read port.
// The block takes no new beat while a search runs, but a finished result
// waits in the output register while the next beats are taken.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic        [stbs_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic        [stbs_pkg::IDX_W-1:0]   entry_index,
	input  logic signed [stbs_pkg::DATA_W-1:0]  data_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found
);

	stbs_pkg::cmd_t cmd;
	stbs_pkg::sts_t sts;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.entry_index (entry_index),
		.data_value  (data_value),
		.found       (found),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
